// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the scale-and-smooth block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg
// Shared types, constants and helper functions for the sensor channel
// scale-and-smooth block.
// ----------------------------------------------------------------------------
package scss_pkg;

    // Field and datapath widths
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIFF_W    = DATA_W + 1;
    localparam int unsigned WEIGHT_W  = 17;
    localparam int unsigned PLO_W     = 2 * DATA_W;
    localparam int unsigned CORR_W    = DATA_W + 2;
    localparam int unsigned PROD_W    = 66;
    localparam int unsigned DIV_ITERS = PROD_W / 2;
    localparam int unsigned DIV_CNT_W = 6;
    localparam int unsigned Q_W       = 41;
    localparam int unsigned SUM_W     = Q_W + 2;
    localparam int unsigned ACC_W     = 50;
    localparam int unsigned SAT_IN_W  = 48;
    localparam int unsigned IDX_W     = 3;

    // Q1.16 unity weight and rounding half for the filter
    localparam logic [WEIGHT_W-1:0]    WEIGHT_ONE = 17'h1_0000;
    localparam logic signed [ACC_W-1:0] ACC_HALF  = 50'sd32768;

    // Quotient cap of the calibration divide
    localparam logic [Q_W-1:0] Q_CAP = 41'h100_0000_0000;

    // Saturation limits
    localparam logic signed [SAT_IN_W-1:0] S32_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [SAT_IN_W-1:0] S32_MIN = 48'shFFFF_8000_0000;

    // Source selection
    typedef enum logic [1:0] {
        MODE_LIVE    = 2'd0,
        MODE_SIM_RAW = 2'd1,
        MODE_SIM_OUT = 2'd2,
        MODE_HOLD    = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_INPUT_MIN  = 3'd0,
        REG_INPUT_MAX  = 3'd1,
        REG_SCALED_MIN = 3'd2,
        REG_SCALED_MAX = 3'd3,
        REG_WEIGHT     = 3'd4,
        REG_SIM_MODE   = 3'd5,
        REG_SIM_RAW    = 3'd6,
        REG_SIM_OUT    = 3'd7
    } reg_idx_t;

    // Configuration register bank
    typedef struct packed {
        logic signed [DATA_W-1:0] input_min;
        logic signed [DATA_W-1:0] input_max;
        logic signed [DATA_W-1:0] scaled_min;
        logic signed [DATA_W-1:0] scaled_max;
        logic [WEIGHT_W-1:0]      smoothing_weight;
        mode_t                    sim_mode;
        logic signed [DATA_W-1:0] sim_raw_value;
        logic signed [DATA_W-1:0] sim_out_value;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic diff;
        logic mag;
        logic mul_lo;
        logic mul_fix;
        logic div_step;
        logic scale;
        logic seed;
        logic sm_a;
        logic sm_b;
        logic sm_c;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic span_zero;
    } stat_t;

    // Clamp a wide signed value into the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX[DATA_W-1:0];
        end else if (v < S32_MIN) begin
            r = S32_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // One restoring-divide step: returns {quotient bit, new remainder}
    function automatic logic [DIFF_W:0] div_step(input logic [DIFF_W-1:0] rem,
                                                 input logic              bit_in,
                                                 input logic [DIFF_W-1:0] d);
        logic [DIFF_W:0] sh;
        logic [DIFF_W:0] dif;
        logic [DIFF_W:0] r;
        sh  = {rem, bit_in};
        dif = sh - {1'b0, d};
        if (sh >= {1'b0, d}) begin
            r = {1'b1, dif[DIFF_W-1:0]};
        end else begin
            r = {1'b0, sh[DIFF_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/scss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scss_cfg_regs
// Configuration register bank, written through the cfg write channel.
// ----------------------------------------------------------------------------
module scss_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scss_pkg::IDX_W-1:0]    cfg_index,
    input  logic [scss_pkg::DATA_W-1:0]   cfg_data,
    output scss_pkg::cfg_t                cfg_o
);
    import scss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_INPUT_MIN:  cfg_next.input_min        = cfg_data;
                REG_INPUT_MAX:  cfg_next.input_max        = cfg_data;
                REG_SCALED_MIN: cfg_next.scaled_min       = cfg_data;
                REG_SCALED_MAX: cfg_next.scaled_max       = cfg_data;
                REG_WEIGHT:     cfg_next.smoothing_weight = cfg_data[WEIGHT_W-1:0];
                REG_SIM_MODE:   cfg_next.sim_mode         = mode_t'(cfg_data[1:0]);
                REG_SIM_RAW:    cfg_next.sim_raw_value    = cfg_data;
                REG_SIM_OUT:    cfg_next.sim_out_value    = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_min        <= '0;
            cfg_reg.input_max        <= 32'sh0001_0000;
            cfg_reg.scaled_min       <= '0;
            cfg_reg.scaled_max       <= 32'sh0001_0000;
            cfg_reg.smoothing_weight <= '0;
            cfg_reg.sim_mode         <= MODE_LIVE;
            cfg_reg.sim_raw_value    <= '0;
            cfg_reg.sim_out_value    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/scss_ctrl.sv =====
// ----------------------------------------------------------------------------
// scss_ctrl
// Sequencer for one transaction: calibration steps, divider iterations,
// filter update and hand-off to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                req_type,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  scss_pkg::mode_t     mode,
    input  scss_pkg::stat_t     stat_i,
    output scss_pkg::cmd_t      cmd_o
);
    import scss_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_DIFF    = 11'b000_0000_0010,
        ST_MAG     = 11'b000_0000_0100,
        ST_MUL_LO  = 11'b000_0000_1000,
        ST_MUL_FIX = 11'b000_0001_0000,
        ST_DIV     = 11'b000_0010_0000,
        ST_SCALE   = 11'b000_0100_0000,
        ST_FILT    = 11'b000_1000_0000,
        ST_SM_B    = 11'b001_0000_0000,
        ST_SM_C    = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 restart_pending_reg, restart_pending_next;
    mode_t                last_mode_reg, last_mode_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 in_accept;
    logic                 out_free;
    logic                 calibrate;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign calibrate = ((mode == MODE_LIVE) || (mode == MODE_SIM_RAW)) && !stat_i.span_zero;

    // Next state and command decode
    always_comb begin
        state_next           = state_reg;
        div_cnt_next         = div_cnt_reg;
        restart_pending_next = restart_pending_reg;
        last_mode_next       = last_mode_reg;
        m_valid_next         = m_valid_reg;
        cmd_o                = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    cmd_o.capture = 1'b1;
                    if (req_type) begin
                        restart_pending_next = 1'b1;
                        state_next           = ST_OUT;
                    end else if (calibrate) begin
                        state_next = ST_DIFF;
                    end else begin
                        state_next = ST_FILT;
                    end
                end
            end
            ST_DIFF: begin
                cmd_o.diff = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                cmd_o.mag  = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd_o.mul_lo = 1'b1;
                state_next   = ST_MUL_FIX;
            end
            ST_MUL_FIX: begin
                cmd_o.mul_fix = 1'b1;
                div_cnt_next  = DIV_CNT_W'(DIV_ITERS - 1);
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd_o.div_step = 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = ST_SCALE;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_SCALE: begin
                cmd_o.scale = 1'b1;
                state_next  = ST_FILT;
            end
            ST_FILT: begin
                // Reseed on pending restart or a change of source mode
                last_mode_next       = mode;
                restart_pending_next = 1'b0;
                if (restart_pending_reg || (mode != last_mode_reg)) begin
                    cmd_o.seed = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd_o.sm_a = 1'b1;
                    state_next = ST_SM_B;
                end
            end
            ST_SM_B: begin
                cmd_o.sm_b = 1'b1;
                state_next = ST_SM_C;
            end
            ST_SM_C: begin
                cmd_o.sm_c = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd_o.out_load = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            div_cnt_reg         <= '0;
            restart_pending_reg <= 1'b1;
            last_mode_reg       <= MODE_LIVE;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            div_cnt_reg         <= div_cnt_next;
            restart_pending_reg <= restart_pending_next;
            last_mode_reg       <= last_mode_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    // Checks
    `ASSERT_IMPLIES(a_load_into_free_slot, aclk, aresetn, cmd_o.out_load, !m_valid_reg || m_tready)
    `ASSERT_NEXT(a_accept_starts_work, aclk, aresetn, in_accept, state_reg != ST_IDLE)
    `ASSERT_NEXT(a_div_exit, aclk, aresetn, (state_reg == ST_DIV) && (div_cnt_reg == '0), state_reg == ST_SCALE)
    `ASSERT_NEXT(a_filt_clears_restart, aclk, aresetn, state_reg == ST_FILT, !restart_pending_reg)

endmodule

// ===== design/scss_dpath.sv =====
// ----------------------------------------------------------------------------
// scss_dpath
// Datapath: source select, span differences, split 33x33 multiply,
// two-bit-per-cycle restoring divide, offset with saturation, and the
// exponential smoothing multiply-accumulate.
// ----------------------------------------------------------------------------
module scss_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scss_pkg::cfg_t                cfg_i,
    input  scss_pkg::cmd_t                cmd_i,
    output scss_pkg::stat_t               stat_o,
    input  logic signed [scss_pkg::DATA_W-1:0] raw_sample,
    output logic signed [scss_pkg::DATA_W-1:0] value_unfiltered,
    output logic signed [scss_pkg::DATA_W-1:0] value_filtered,
    output logic                          calib_error
);
    import scss_pkg::*;

    logic signed [DATA_W-1:0] x_reg, cur_reg, filt_reg, last_unf_reg;
    logic signed [DIFF_W-1:0] dx_reg, ds_reg, di_reg;
    logic [DIFF_W-1:0]        a_reg, b_reg, d_reg;
    logic                     neg_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic [CORR_W-1:0]        corr_reg;
    logic [PROD_W-1:0]        dvd_reg;
    logic [DIFF_W-1:0]        rem_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     qovf_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] out_unf_reg, out_filt_reg;
    logic                     out_err_reg;

    logic signed [DIFF_W-1:0] dx_next, ds_next, di_next;
    logic [DIFF_W:0]          st1, st2;
    logic [Q_W+1:0]           q_sh;
    logic [Q_W-1:0]           q_eff;
    logic signed [SUM_W-1:0]  smin_x, q_s, sum;
    logic [WEIGHT_W-1:0]      w_eff, w_inv, mul_b;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [WEIGHT_W:0] mul_b_s;
    logic signed [ACC_W-1:0]  sm_prod;

    assign stat_o.span_zero = (cfg_i.input_max == cfg_i.input_min);

    // Span differences
    assign dx_next = {x_reg[DATA_W-1], x_reg} - {cfg_i.input_min[DATA_W-1], cfg_i.input_min};
    assign ds_next = {cfg_i.scaled_max[DATA_W-1], cfg_i.scaled_max}
                   - {cfg_i.scaled_min[DATA_W-1], cfg_i.scaled_min};
    assign di_next = {cfg_i.input_max[DATA_W-1], cfg_i.input_max}
                   - {cfg_i.input_min[DATA_W-1], cfg_i.input_min};

    // Two divider steps per cycle, quotient overflow kept sticky
    assign st1  = div_step(rem_reg, dvd_reg[PROD_W-1], d_reg);
    assign st2  = div_step(st1[DIFF_W-1:0], dvd_reg[PROD_W-2], d_reg);
    assign q_sh = {q_reg, st1[DIFF_W], st2[DIFF_W]};

    // Offset by scaled_min, quotient capped
    assign q_eff  = (qovf_reg || (q_reg > Q_CAP)) ? Q_CAP : q_reg;
    assign smin_x = {{(SUM_W-DATA_W){cfg_i.scaled_min[DATA_W-1]}}, cfg_i.scaled_min};
    assign q_s    = $signed({2'b00, q_eff});
    assign sum    = neg_reg ? (smin_x - q_s) : (smin_x + q_s);

    // Smoothing multiplier shared between the two weighted terms
    assign w_eff   = cfg_i.smoothing_weight[WEIGHT_W-1] ? WEIGHT_ONE : cfg_i.smoothing_weight;
    assign w_inv   = WEIGHT_ONE - w_eff;
    assign mul_a   = cmd_i.sm_a ? cur_reg : filt_reg;
    assign mul_b   = cmd_i.sm_a ? w_inv : w_eff;
    assign mul_b_s = $signed({1'b0, mul_b});
    assign sm_prod = mul_a * mul_b_s;

    // Calibration pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            x_reg <= (cfg_i.sim_mode == MODE_SIM_RAW) ? cfg_i.sim_raw_value : raw_sample;
            case (cfg_i.sim_mode)
                MODE_SIM_OUT: cur_reg <= cfg_i.sim_out_value;
                MODE_HOLD:    cur_reg <= last_unf_reg;
                default:      cur_reg <= cfg_i.scaled_min;
            endcase
        end else if (cmd_i.scale) begin
            cur_reg <= sat32({{(SAT_IN_W-SUM_W){sum[SUM_W-1]}}, sum});
        end

        if (cmd_i.diff) begin
            dx_reg <= dx_next;
            ds_reg <= ds_next;
            di_reg <= di_next;
        end

        if (cmd_i.mag) begin
            a_reg   <= dx_reg[DIFF_W-1] ? (-dx_reg) : dx_reg;
            b_reg   <= ds_reg[DIFF_W-1] ? (-ds_reg) : ds_reg;
            d_reg   <= di_reg[DIFF_W-1] ? (-di_reg) : di_reg;
            neg_reg <= dx_reg[DIFF_W-1] ^ ds_reg[DIFF_W-1] ^ di_reg[DIFF_W-1];
        end

        // Low 32x32 partial product plus the terms of the top magnitude bits
        if (cmd_i.mul_lo) begin
            plo_reg  <= a_reg[DATA_W-1:0] * b_reg[DATA_W-1:0];
            corr_reg <= CORR_W'(a_reg[DATA_W] ? b_reg[DATA_W-1:0] : '0)
                      + CORR_W'(b_reg[DATA_W] ? a_reg[DATA_W-1:0] : '0)
                      + {1'b0, (a_reg[DATA_W] & b_reg[DATA_W]), {DATA_W{1'b0}}};
        end

        // Assemble the product and start the divide
        if (cmd_i.mul_fix) begin
            dvd_reg  <= {2'b00, plo_reg} + {corr_reg, {DATA_W{1'b0}}};
            rem_reg  <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
        end else if (cmd_i.div_step) begin
            dvd_reg  <= {dvd_reg[PROD_W-3:0], 2'b00};
            rem_reg  <= st2[DIFF_W-1:0];
            q_reg    <= q_sh[Q_W-1:0];
            qovf_reg <= qovf_reg | (|q_sh[Q_W+1:Q_W]);
        end

        // Filter accumulator
        if (cmd_i.sm_a) begin
            acc_reg <= sm_prod + ACC_HALF;
        end else if (cmd_i.sm_b) begin
            acc_reg <= acc_reg + sm_prod;
        end

        // Output payload
        if (cmd_i.out_load) begin
            out_unf_reg  <= last_unf_reg;
            out_filt_reg <= filt_reg;
            out_err_reg  <= stat_o.span_zero;
        end
    end

    // Channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg     <= '0;
            last_unf_reg <= '0;
        end else begin
            if (cmd_i.seed) begin
                filt_reg     <= cur_reg;
                last_unf_reg <= cur_reg;
            end else if (cmd_i.sm_c) begin
                filt_reg     <= sat32({{(SAT_IN_W-(ACC_W-16)){acc_reg[ACC_W-1]}},
                                       acc_reg[ACC_W-1:16]});
                last_unf_reg <= cur_reg;
            end
        end
    end

    assign value_unfiltered = out_unf_reg;
    assign value_filtered   = out_filt_reg;
    assign calib_error      = out_err_reg;

endmodule

// ===== design/sensor_channel_scale_and_smooth_unit.sv =====
// ----------------------------------------------------------------------------
// sensor_channel_scale_and_smooth_unit
// Two-point linear calibration of one sensor channel with exponential
// smoothing of the calibrated value, signed Q16.16 throughout.
// ----------------------------------------------------------------------------
//   s_*: tdata carries the raw sample, tuser the request kind (process one
//   sample, or restart the filter only). Each accepted transaction yields one
//   result on m_*: calibrated value, smoothed value, calibration error flag.
//   Registers must be written through the cfg_* channel only while idle; the
//   block itself does not enforce this. A calibrated sample passes through
//   difference, magnitude, two multiply steps, the divider iterations at two
//   quotient bits each, scale and the filter update; a seed step replaces the
//   filter update when the filter is reseeded. Simulated-output, hold and
//   empty-span samples skip the calibration steps. A restart request goes
//   straight to the output register. One transaction is in work at a time;
//   s_tready rises with m_tvalid. While m_tready is low the next transaction
//   is accepted and worked on, then waits for the output register.
//   Reset (aresetn low, synchronous) loads the register defaults, clears the
//   filter state and arms a restart, so the first sample seeds the filter.
// ----------------------------------------------------------------------------
module sensor_channel_scale_and_smooth_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [scss_pkg::DATA_W-1:0]  s_tdata,   // [31:0] raw_sample
    input  logic [0:0]                   s_tuser,   // [0] req_type
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [2*scss_pkg::DATA_W-1:0] m_tdata,  // [31:0] value_unfiltered, [63:32] value_filtered
    output logic [0:0]                   m_tuser,   // [0] calib_error
    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [scss_pkg::IDX_W-1:0]   cfg_index,
    input  logic [scss_pkg::DATA_W-1:0]  cfg_data
);
    import scss_pkg::*;

    cfg_t                     cfg;
    cmd_t                     cmd;
    stat_t                    stat;
    logic signed [DATA_W-1:0] value_unfiltered;
    logic signed [DATA_W-1:0] value_filtered;
    logic                     calib_error;

    scss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    scss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .mode     (cfg.sim_mode),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    scss_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_i            (cfg),
        .cmd_i            (cmd),
        .stat_o           (stat),
        .raw_sample       ($signed(s_tdata)),
        .value_unfiltered (value_unfiltered),
        .value_filtered   (value_filtered),
        .calib_error      (calib_error)
    );

    // Result packing
    assign m_tdata = {value_filtered, value_unfiltered};
    assign m_tuser = calib_error;

endmodule
